// ===== hw/rtl/ipv4_dotted_text_parser_defines.svh =====
// Assertion macros shared by the dotted IPv4 text parser checkers.
`ifndef IPV4_DOTTED_TEXT_PARSER_DEFINES_SVH
`define IPV4_DOTTED_TEXT_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define IPV4P_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define IPV4P_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ipv4p_pkg.sv =====
// Shared widths and types of the dotted IPv4 text parser.
`default_nettype none

package ipv4p_pkg;

   localparam int CHAR_W  = 8;
   localparam int ADDR_W  = 32;
   localparam int PARTS   = 4;
   localparam int COUNT_W = 3;

   // Finished parts of one string, handed to the assembly stage.
   typedef struct packed {
      logic [PARTS-1:0][ADDR_W-1:0] part;
      logic [COUNT_W-1:0]           count;
      logic                         bad_stop;
   } ipv4p_snap_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ipv4p_if.sv =====
// Request and response channel interfaces of the dotted IPv4 text parser.
`default_nettype none

interface ipv4p_req_if;
   logic                          valid;
   logic                          ready;
   logic [ipv4p_pkg::CHAR_W-1:0]  char_code;
   logic                          end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface ipv4p_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ipv4p_pkg::ADDR_W-1:0]  address;
   logic                          error;

   modport source (output valid, output address, output error, input ready);
   modport sink   (input valid, input address, input error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ipv4p_assemble.sv =====
// Range checks, address assembly and output register of the IPv4 text parser.
`default_nettype none

module ipv4p_assemble (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      snap_valid,
   input  ipv4p_pkg::ipv4p_snap_type snap,
   output logic                      snap_free,
   ipv4p_rsp_if.source               rsp_ch
);

   localparam logic [ipv4p_pkg::COUNT_W-1:0] ONE_PART   = 3'd1;
   localparam logic [ipv4p_pkg::COUNT_W-1:0] TWO_PARTS  = 3'd2;
   localparam logic [ipv4p_pkg::COUNT_W-1:0] THREE_PARTS = 3'd3;
   localparam logic [ipv4p_pkg::COUNT_W-1:0] FOUR_PARTS = 3'd4;

   logic                          rsp_valid_ff;
   logic [ipv4p_pkg::ADDR_W-1:0]  rsp_address_ff;
   logic                          rsp_error_ff;
   logic [ipv4p_pkg::ADDR_W-1:0]  rsp_address_in;
   logic                          rsp_error_in;
   logic [ipv4p_pkg::PARTS-1:0]   fits8;
   logic                          b_fits24;
   logic                          c_fits16;
   logic                          out_free;

   always_comb begin
      for (int i = 0; i < ipv4p_pkg::PARTS; i++) begin
         fits8[i] = (snap.part[i][31:8] == 24'd0);
      end
   end

   assign b_fits24 = (snap.part[1][31:24] == 8'd0);
   assign c_fits16 = (snap.part[2][31:16] == 16'd0);

   always_comb begin
      rsp_address_in = '1;
      rsp_error_in   = 1'b1;
      if (!snap.bad_stop) begin
         case (snap.count)
            ONE_PART: begin
               rsp_address_in = snap.part[0];
               rsp_error_in   = 1'b0;
            end
            TWO_PARTS: begin
               if (fits8[0] && b_fits24) begin
                  rsp_address_in = {snap.part[0][7:0], snap.part[1][23:0]};
                  rsp_error_in   = 1'b0;
               end
            end
            THREE_PARTS: begin
               if (fits8[0] && fits8[1] && c_fits16) begin
                  rsp_address_in = {snap.part[0][7:0], snap.part[1][7:0],
                                    snap.part[2][15:0]};
                  rsp_error_in   = 1'b0;
               end
            end
            FOUR_PARTS: begin
               if (&fits8) begin
                  rsp_address_in = {snap.part[0][7:0], snap.part[1][7:0],
                                    snap.part[2][7:0], snap.part[3][7:0]};
                  rsp_error_in   = 1'b0;
               end
            end
            default: begin
               rsp_error_in = 1'b1;
            end
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign snap_free = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && snap_valid) begin
         rsp_address_ff <= rsp_address_in;
         rsp_error_ff   <= rsp_error_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.address = rsp_address_ff;
   assign rsp_ch.error   = rsp_error_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4_dotted_text_parser.sv =====
// Dotted IPv4 address text parser: one character per request, one address
// per string. Each request is registered, then logic scales the current part
// by its radix (10, 8 or 16) and adds the digit; a string ending (NUL or
// end_of_text) moves the finished parts to a check-and-assemble stage whose
// result register drives rsp. The block takes one character every cycle while
// no ending waits for room in that stage, limited by the radix multiply-add on
// the part accumulator; an accepted ending passes the request, finished-string
// and result registers to rsp. Malformed text or an out-of-range part gives
// address 0xFFFFFFFF with error set. No clearing pass after reset.
`default_nettype none

module ipv4_dotted_text_parser (
   input  logic        clock,
   input  logic        reset,
   ipv4p_req_if.sink   req_ch,
   ipv4p_rsp_if.source rsp_ch
);

   localparam logic [2:0] PH_START   = 3'd0;
   localparam logic [2:0] PH_ZERO    = 3'd1;
   localparam logic [2:0] PH_DIGITS  = 3'd2;
   localparam logic [2:0] PH_DOT4    = 3'd3;
   localparam logic [2:0] PH_STOPPED = 3'd4;

   localparam logic [1:0] RX_DEC = 2'd0;
   localparam logic [1:0] RX_OCT = 2'd1;
   localparam logic [1:0] RX_HEX = 2'd2;

   localparam logic [ipv4p_pkg::CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [ipv4p_pkg::CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [ipv4p_pkg::CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [ipv4p_pkg::CHAR_W-1:0] CH_LOW_X = 8'h78;
   localparam logic [ipv4p_pkg::CHAR_W-1:0] CH_UP_X  = 8'h58;
   localparam logic [ipv4p_pkg::CHAR_W-1:0] CH_CASE  = 8'h20;
   localparam logic [ipv4p_pkg::CHAR_W-1:0] CH_HEX_BIAS = 8'h57;

   localparam logic [ipv4p_pkg::COUNT_W-1:0] PART_LIMIT =
      ipv4p_pkg::COUNT_W'(ipv4p_pkg::PARTS);

   // Request register
   logic                          req_valid_ff;
   logic [ipv4p_pkg::CHAR_W-1:0]  req_char_ff;
   logic                          req_end_ff;

   // Parse state
   logic [2:0]                                     phase_ff, phase_in;
   logic [ipv4p_pkg::COUNT_W-1:0]                  count_ff, count_in;
   logic [1:0]                                     radix_ff, radix_in;
   logic                                           bad_ff, bad_in;
   logic [ipv4p_pkg::PARTS-1:0][ipv4p_pkg::ADDR_W-1:0] part_ff, part_in;

   // Finished-string stage
   logic                       snap_valid_ff;
   ipv4p_pkg::ipv4p_snap_type  snap_ff, snap_in;
   logic                       snap_free;

   logic                          is_nul;
   logic                          is_fin;
   logic                          is_white;
   logic                          is_dec;
   logic                          is_hex_letter;
   logic [ipv4p_pkg::CHAR_W-1:0]  lower_char;
   logic [3:0]                    dig_value;
   logic [1:0]                    slot;
   logic [1:0]                    dig_radix;
   logic [ipv4p_pkg::ADDR_W-1:0]  dig_base;
   logic [ipv4p_pkg::ADDR_W-1:0]  dig_scaled;
   logic [ipv4p_pkg::ADDR_W-1:0]  acc_next;
   logic                          run_digit;
   logic                          in_go;

   assign is_nul   = (req_char_ff == CH_NUL);
   assign is_fin   = is_nul || req_end_ff;
   assign is_white = req_char_ff inside {8'h20, 8'h09, 8'h0A, 8'h0D};
   assign is_dec   = req_char_ff inside {[8'h30:8'h39]};
   // Folding case maps exactly A-F and a-f onto a-f
   assign lower_char    = req_char_ff | CH_CASE;
   assign is_hex_letter = lower_char inside {[8'h61:8'h66]};
   assign dig_value     = is_dec ? 4'(req_char_ff - CH_ZERO)
                                 : 4'(lower_char - CH_HEX_BIAS);

   assign slot      = count_ff[1:0];
   assign dig_radix = (phase_ff == PH_START) ? RX_DEC :
                      (phase_ff == PH_ZERO)  ? RX_OCT : radix_ff;
   assign dig_base  = (phase_ff == PH_START) ? '0 : part_ff[slot];

   always_comb begin
      case (dig_radix)
         RX_HEX:  dig_scaled = {dig_base[27:0], 4'd0};
         RX_OCT:  dig_scaled = {dig_base[28:0], 3'd0};
         default: dig_scaled = {dig_base[28:0], 3'd0} + {dig_base[30:0], 1'b0};
      endcase
   end

   assign acc_next = dig_scaled + {28'd0, dig_value};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      radix_in  = radix_ff;
      bad_in    = bad_ff;
      part_in   = part_ff;
      run_digit = 1'b0;
      if (!is_nul) begin
         case (phase_ff)
            PH_START: begin
               part_in[slot] = '0;
               radix_in      = RX_DEC;
               if (req_char_ff == CH_ZERO) begin
                  phase_in = PH_ZERO;
               end else begin
                  run_digit = 1'b1;
               end
            end
            PH_ZERO: begin
               if (req_char_ff == CH_LOW_X || req_char_ff == CH_UP_X) begin
                  radix_in = RX_HEX;
                  phase_in = PH_DIGITS;
               end else begin
                  radix_in  = RX_OCT;
                  run_digit = 1'b1;
               end
            end
            PH_DIGITS: begin
               run_digit = 1'b1;
            end
            PH_DOT4: begin
               bad_in   = !is_white;
               phase_in = PH_STOPPED;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (run_digit) begin
            if (is_dec || (is_hex_letter && dig_radix == RX_HEX)) begin
               part_in[slot] = acc_next;
               phase_in      = PH_DIGITS;
            end else begin
               count_in = count_ff + 3'd1;
               if (req_char_ff == CH_DOT) begin
                  phase_in = (count_in < PART_LIMIT) ? PH_START : PH_DOT4;
               end else begin
                  bad_in   = !is_white;
                  phase_in = PH_STOPPED;
               end
            end
         end
      end

      // Close the open part at the end of the string
      snap_in.part     = part_in;
      snap_in.count    = count_in;
      snap_in.bad_stop = bad_in;
      if (phase_in == PH_START) begin
         snap_in.part[count_in[1:0]] = '0;
         snap_in.count               = count_in + 3'd1;
      end else if (phase_in == PH_ZERO || phase_in == PH_DIGITS) begin
         snap_in.count = count_in + 3'd1;
      end

      if (is_fin) begin
         phase_in = PH_START;
         count_in = '0;
         radix_in = RX_DEC;
         bad_in   = 1'b0;
      end
   end

   // An ending character waits only for room in the finished-string stage
   assign in_go        = req_valid_ff && (!is_fin || snap_free);
   assign req_ch.ready = !req_valid_ff || in_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         snap_valid_ff <= 1'b0;
         phase_ff      <= PH_START;
         count_ff      <= '0;
         radix_ff      <= RX_DEC;
         bad_ff        <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            req_valid_ff <= req_ch.valid;
         end
         if (snap_free) begin
            snap_valid_ff <= in_go && is_fin;
         end
         if (in_go) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            radix_ff <= radix_in;
            bad_ff   <= bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         req_char_ff <= req_ch.char_code;
         req_end_ff  <= req_ch.end_of_text;
      end
      if (in_go) begin
         part_ff <= part_in;
      end
      if (in_go && is_fin) begin
         snap_ff <= snap_in;
      end
   end

   ipv4p_assemble u_assemble (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid_ff),
      .snap       (snap_ff),
      .snap_free  (snap_free),
      .rsp_ch     (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4p_checker.sv =====
// Port-level checker for the dotted IPv4 text parser and its bind.
`default_nettype none
`include "ipv4_dotted_text_parser_defines.svh"

module ipv4p_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [ipv4p_pkg::ADDR_W-1:0]  rsp_address,
   input logic                          rsp_error
);

   // An error result always carries the all-ones address
   `IPV4P_ASSERT_NOW(a_error_all_ones, rsp_valid && rsp_error, rsp_address == '1, "error without all-ones address")

   // A stalled response holds
   `IPV4P_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_address) && $stable(rsp_error), "stalled response changed")

   // No response can reach the output straight after reset
   `IPV4P_ASSERT_NOW(a_reset_latency, $past(reset), !rsp_valid ##1 !rsp_valid, "response too soon after reset")

   // With the output empty the block takes a request
   `IPV4P_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "request blocked while output empty")

endmodule

bind ipv4_dotted_text_parser ipv4p_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_address (rsp_ch.address),
   .rsp_error   (rsp_ch.error)
);

`default_nettype wire

// ===== verif/ipv4_dotted_text_parser_test.sv =====
// Self-checking testbench for the dotted IPv4 text parser: random text strings, checked addresses.
`timescale 1ns / 100ps

module ipv4_dotted_text_parser_test;

   typedef logic [ipv4p_pkg::CHAR_W-1:0] char_type;

   typedef struct packed {
      char_type code;
      logic     last;
   } text_req_type;

   typedef struct packed {
      logic [ipv4p_pkg::ADDR_W-1:0] address;
      logic                         error;
   } addr_result_type;

   typedef enum logic [2:0] {
      PARSE_START,
      PARSE_ZERO,
      PARSE_DIGITS,
      PARSE_DOT4,
      PARSE_STOPPED
   } parse_phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   typedef enum int {
      END_NUL,
      END_NUL_FLAG,
      END_FLAG_LAST
   } text_end_type;

   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_LF    = 8'h0A;
   localparam char_type CH_CR    = 8'h0D;
   localparam char_type CH_SPACE = 8'h20;

   logic clock = 1'b0;
   logic reset;

   ipv4p_req_if req_ch ();
   ipv4p_rsp_if rsp_ch ();

   ipv4_dotted_text_parser i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state
   parse_phase_type                 scan_phase;
   logic [ipv4p_pkg::COUNT_W-1:0]   parts_done;
   radix_type                       part_radix;
   logic [ipv4p_pkg::ADDR_W-1:0]    part_acc [ipv4p_pkg::PARTS];
   logic                            stop_bad;

   text_req_type    pending_chars[$];
   addr_result_type expected_addresses[$];
   char_type        text_buf[$];

   int   send_idle_pct;
   int   stall_pct;
   int   mismatch_count;
   int   queued_chars;
   int   queued_strings;
   logic req_taken;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic is_blank(char_type c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic void clear_parse_state();
      scan_phase = PARSE_START;
      parts_done = '0;
      part_radix = RADIX_DEC;
      for (int i = 0; i < ipv4p_pkg::PARTS; i++) part_acc[i] = '0;
      stop_bad = 1'b0;
   endfunction

   // Fold one character into the current part, or close the part.
   function automatic void scale_part(char_type c);
      logic [1:0]                   k;
      logic [ipv4p_pkg::ADDR_W-1:0] mult;
      char_type                     lc;
      k = parts_done[1:0];
      mult = (part_radix == RADIX_HEX) ? 16 : (part_radix == RADIX_OCT) ? 8 : 10;
      lc = (c >= "A" && c <= "F") ? c + 8'd32 : c;
      if (c >= "0" && c <= "9") begin
         part_acc[k] = part_acc[k] * mult + ipv4p_pkg::ADDR_W'(c - "0");
         scan_phase = PARSE_DIGITS;
      end else if (part_radix == RADIX_HEX && lc >= "a" && lc <= "f") begin
         part_acc[k] = part_acc[k] * 16 + ipv4p_pkg::ADDR_W'(lc - "a") + 10;
         scan_phase = PARSE_DIGITS;
      end else begin
         parts_done = parts_done + 1'b1;
         if (c == ".") begin
            scan_phase = (parts_done < 4) ? PARSE_START : PARSE_DOT4;
         end else begin
            stop_bad = !is_blank(c);
            scan_phase = PARSE_STOPPED;
         end
      end
   endfunction

   function automatic void take_request(char_type c, logic last);
      logic [ipv4p_pkg::ADDR_W-1:0] a, b, p2, d;
      addr_result_type              r;
      if (c != CH_NUL) begin
         case (scan_phase)
            PARSE_START: begin
               part_acc[parts_done[1:0]] = '0;
               part_radix = RADIX_DEC;
               if (c == "0") scan_phase = PARSE_ZERO;
               else scale_part(c);
            end
            PARSE_ZERO: begin
               if (c == "x" || c == "X") begin
                  part_radix = RADIX_HEX;
                  scan_phase = PARSE_DIGITS;
               end else begin
                  part_radix = RADIX_OCT;
                  scale_part(c);
               end
            end
            PARSE_DIGITS: scale_part(c);
            PARSE_DOT4: begin
               stop_bad = !is_blank(c);
               scan_phase = PARSE_STOPPED;
            end
            default: ;
         endcase
      end
      if (c == CH_NUL || last) begin
         // an open part counts, even with no digits
         if (scan_phase == PARSE_START) begin
            part_acc[parts_done[1:0]] = '0;
            parts_done = parts_done + 1'b1;
         end else if (scan_phase == PARSE_ZERO || scan_phase == PARSE_DIGITS) begin
            parts_done = parts_done + 1'b1;
         end
         a = part_acc[0];
         b = part_acc[1];
         p2 = part_acc[2];
         d = part_acc[3];
         r.address = '1;
         r.error = 1'b1;
         if (!stop_bad) begin
            case (parts_done)
               3'd1: begin
                  r.address = a;
                  r.error = 1'b0;
               end
               3'd2: begin
                  if (a <= 32'hFF && b <= 32'hFF_FFFF) begin
                     r.address = (a << 24) | b;
                     r.error = 1'b0;
                  end
               end
               3'd3: begin
                  if (a <= 32'hFF && b <= 32'hFF && p2 <= 32'hFFFF) begin
                     r.address = (a << 24) | (b << 16) | p2;
                     r.error = 1'b0;
                  end
               end
               3'd4: begin
                  if (a <= 32'hFF && b <= 32'hFF && p2 <= 32'hFF && d <= 32'hFF) begin
                     r.address = (a << 24) | (b << 16) | (p2 << 8) | d;
                     r.error = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         expected_addresses.push_back(r);
         clear_parse_state();
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Move text_buf into the request queue with the chosen ending.
   task automatic queue_text(text_end_type how);
      int n;
      n = text_buf.size();
      for (int i = 0; i < n; i++) begin
         pending_chars.push_back('{text_buf[i], how == END_FLAG_LAST && i == n - 1});
      end
      if (how != END_FLAG_LAST || n == 0) begin
         pending_chars.push_back('{CH_NUL, how != END_NUL});
         n++;
      end
      queued_chars += n;
      queued_strings++;
      text_buf.delete();
   endtask

   task automatic queue_string(string s, text_end_type how);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
      queue_text(how);
   endtask

   task automatic queue_random_text();
      int       n_parts;
      int       r;
      string    s;
      char_type ch;
      text_buf.delete();
      if ($urandom_range(99) < 12) begin
         // noise: arbitrary bytes
         repeat ($urandom_range(1, 6)) text_buf.push_back(char_type'($urandom_range(1, 255)));
      end else begin
         n_parts = ($urandom_range(99) < 4) ? 5 : $urandom_range(1, 4);
         for (int p = 0; p < n_parts; p++) begin
            if (p != 0) text_buf.push_back(".");
            r = $urandom_range(99);
            if (r < 38) begin
               s = $sformatf("%0d", $urandom_range(0, 255));
            end else if (r < 50) begin
               s = $sformatf("%0d", $urandom);
            end else if (r < 60) begin
               s = $sformatf("0%0o", $urandom_range(0, 255));
            end else if (r < 74) begin
               s = $sformatf("0x%0h", ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 255));
            end else if (r < 84) begin
               // long digit runs: wrap, and 8/9 in octal
               s = ($urandom_range(1) == 1) ? "0" : "";
               repeat ($urandom_range(1, 13)) s = {s, $sformatf("%0d", $urandom_range(9))};
            end else if (r < 90) begin
               s = "0x";
               repeat ($urandom_range(1, 10)) s = {s, $sformatf("%0h", $urandom_range(15))};
            end else if (r < 95) begin
               s = "";
            end else begin
               s = ($urandom_range(1) == 1) ? "0x" : "0";
            end
            for (int i = 0; i < s.len(); i++) begin
               ch = s[i];
               if (((ch >= "a" && ch <= "f") || ch == "x") && $urandom_range(1) == 1) ch -= 8'd32;
               text_buf.push_back(ch);
            end
         end
         if ($urandom_range(99) < 6) text_buf.push_back(".");
         r = $urandom_range(99);
         if (r >= 75) begin
            if (r < 90) begin
               case ($urandom_range(3))
                  0: text_buf.push_back(CH_SPACE);
                  1: text_buf.push_back(CH_TAB);
                  2: text_buf.push_back(CH_LF);
                  default: text_buf.push_back(CH_CR);
               endcase
            end else begin
               text_buf.push_back(char_type'($urandom_range(1, 255)));
            end
            // trailing bytes after the stop are ignored
            repeat ($urandom_range(0, 3)) text_buf.push_back(char_type'($urandom_range(1, 255)));
         end
      end
      queue_text(text_end_type'($urandom_range(2)));
   endtask

   task automatic wait_drained();
      while (pending_chars.size() != 0 || req_ch.valid || expected_addresses.size() != 0)
         @(negedge clock);
   endtask

   always @(negedge clock) begin : drive_requests
      text_req_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.char_code <= '0;
         req_ch.end_of_text <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         if (!req_ch.valid || req_taken) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_chars.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.char_code <= item.code;
               req_ch.end_of_text <= item.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_channels
      addr_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) take_request(req_ch.char_code, req_ch.end_of_text);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_addresses.size() == 0) begin
               report_mismatch($sformatf("unexpected address %h error %b",
                                         rsp_ch.address, rsp_ch.error));
            end else begin
               want = expected_addresses.pop_front();
               if (rsp_ch.address !== want.address)
                  report_mismatch($sformatf("address %h, want %h", rsp_ch.address, want.address));
               if (rsp_ch.error !== want.error)
                  report_mismatch($sformatf("error flag %b, want %b", rsp_ch.error, want.error));
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int chars_goal;
      int strings_goal;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.char_code = '0;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready = 1'b0;
      req_taken = 1'b0;
      send_idle_pct = 0;
      stall_pct = 0;
      mismatch_count = 0;
      queued_chars = 0;
      queued_strings = 0;
      clear_parse_state();

      // directed strings
      queue_string("", END_NUL_FLAG);
      queue_string("0x", END_FLAG_LAST);
      queue_string("09.", END_NUL);
      queue_string("1.2.3.4.\t", END_FLAG_LAST);
      queue_string("1#z", END_FLAG_LAST);
      text_buf.push_back(8'hFF);
      queue_text(END_FLAG_LAST);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         chars_goal = queued_chars + 150;
         strings_goal = queued_strings + 12;
         while (queued_chars < chars_goal || queued_strings < strings_goal) queue_random_text();
         wait_drained();
      end

      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
